// ----- hw/rtl/lcwc_pkg.sv -----
// ---------------------------------------------------------------------------
// Load cell weigh conditioner package
// Shared widths, codes and reset values for the weigh conditioner.
// ---------------------------------------------------------------------------
package lcwc_pkg;

  localparam int SampleBitsDef = 24;

  localparam int RawW   = 24;
  localparam int KwW    = 20;
  localparam int ScaleW = 33;
  localparam int WgtW   = 32;
  localparam int AccW   = 32;
  localparam int CntW   = 8;
  localparam int AlphaW = 9;
  localparam int CfgAW  = 2;
  localparam int CfgDW  = 9;

  // Divider: numerator is wide enough for (net << 16).
  localparam int DivNW  = 40;
  localparam int DivDW  = 33;
  localparam int DivRW  = 34;
  localparam int DivCW  = 6;

  localparam logic [1:0] FUNC_WEIGH = 2'd0;
  localparam logic [1:0] FUNC_TARE  = 2'd1;
  localparam logic [1:0] FUNC_CAL   = 2'd2;
  localparam logic [1:0] FUNC_LOAD  = 2'd3;

  localparam logic [2:0] KIND_WEIGHT  = 3'd0;
  localparam logic [2:0] KIND_TARE    = 3'd1;
  localparam logic [2:0] KIND_CAL     = 3'd2;
  localparam logic [2:0] KIND_CAL_REJ = 3'd3;
  localparam logic [2:0] KIND_LOADED  = 3'd4;

  localparam logic [CfgAW-1:0] CFG_SAMPLE_COUNT = 2'd0;
  localparam logic [CfgAW-1:0] CFG_ALPHA_START  = 2'd1;
  localparam logic [CfgAW-1:0] CFG_ALPHA_TARE   = 2'd2;

  localparam logic [CntW-1:0]   SAMPLE_COUNT_RST = 8'd5;
  localparam logic [AlphaW-1:0] ALPHA_START_RST  = 9'd26;
  localparam logic [AlphaW-1:0] ALPHA_TARE_RST   = 9'd77;
  localparam logic [ScaleW-1:0] SCALE_RST        = 33'd57600;

  typedef enum logic [1:0] {
    DOP_AVG,
    DOP_WGT,
    DOP_CAL
  } div_op_t;

endpackage

// ----- hw/rtl/load_cell_weigh_conditioner.sv -----
// ---------------------------------------------------------------------------
// Load cell weigh conditioner
// Batch averaging, tare, scaling, calibration and low-pass filtering of
// load-cell converter words, built around one shared bit-serial divider.
// ---------------------------------------------------------------------------
// Each input transfer carries a converter word and a function code. Weigh and
// tare samples that do not close a batch only add to the batch sum and give
// no result. A sample that closes a batch runs the restoring divider once for
// the average; a tare batch then reports, while a weigh batch runs the divider
// again for the weight quotient and, once the filter is primed, a shift-and-add
// multiply for the low-pass step. A calibrate item that is not rejected runs
// the divider once for the new scale; a load item only loads the scale. The
// divider retires one quotient bit per cycle. The block takes no new item
// while it works, but it does take one while a finished result still waits
// in the output register.
module load_cell_weigh_conditioner
  import lcwc_pkg::*;
#(
  parameter int SAMPLE_BITS = SampleBitsDef
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CfgAW-1:0]         cfg_addr,
  input  logic [CfgDW-1:0]         cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_func,
  input  logic [RawW-1:0]          in_raw_bits,
  input  logic [KwW-1:0]           in_known_weight,
  input  logic signed [ScaleW-1:0] in_scale_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [2:0]               out_kind,
  output logic signed [WgtW-1:0]   out_weight_q,
  output logic [RawW-1:0]          out_average_raw,
  output logic [RawW-1:0]          out_offset_now,
  output logic signed [ScaleW-1:0] out_scale_now,
  output logic                     out_saturated
);

  // Sequencer state codes.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_OUT  = 3'd3;

  localparam int ProdW = ScaleW + AlphaW;

  // Configuration registers.
  logic [CntW-1:0]   sample_count_r;
  logic [AlphaW-1:0] alpha_start_r;
  logic [AlphaW-1:0] alpha_tare_r;
  logic [AlphaW-1:0] alpha_now_r;
  logic              alpha_follows_tare_r;

  // Conditioner state.
  logic [2:0]               state_r;
  logic [RawW-1:0]          offset_r;
  logic signed [ScaleW-1:0] scale_r;
  logic [AccW-1:0]          acc_r;
  logic [CntW-1:0]          bcnt_r;
  logic                     batch_tare_r;
  logic signed [WgtW-1:0]   filt_r;
  logic                     primed_r;

  // Per-item working registers.
  logic [2:0]      kind_r;
  logic [RawW-1:0] avg_r;
  logic            sat_r;
  logic            neg_r;
  logic            net_zero_r;

  // Shared divider.
  div_op_t          div_op_r;
  logic [DivNW-1:0] div_num_r;
  logic [DivDW-1:0] div_den_r;
  logic [DivRW-1:0] div_rem_r;
  logic [DivNW-1:0] div_q_r;
  logic [DivCW-1:0] div_cnt_r;

  // Filter multiply.
  logic signed [ScaleW-1:0] mul_d_r;
  logic signed [ProdW-1:0]  mul_p_r;
  logic [AlphaW-1:0]        mul_a_r;
  logic [3:0]               mul_cnt_r;

  // Output register.
  logic                     out_valid_r;
  logic [2:0]               out_kind_r;
  logic signed [WgtW-1:0]   out_weight_r;
  logic [RawW-1:0]          out_avg_r;
  logic [RawW-1:0]          out_offset_r;
  logic signed [ScaleW-1:0] out_scale_r;
  logic                     out_sat_r;

  logic in_xfer;
  logic out_free;
  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Offset binary sample: the sign bit of the converter word is flipped.
  logic [RawW-1:0] samp;
  assign samp = RawW'(in_raw_bits[SAMPLE_BITS-1:0]) ^ (RawW'(1) << (SAMPLE_BITS - 1));

  // Batch bookkeeping for an incoming weigh or tare sample.
  logic            is_tare;
  logic            restart;
  logic [AccW-1:0] acc_sum;
  logic [CntW-1:0] cnt_inc;
  logic [CntW-1:0] batch_n;
  assign is_tare = (in_func == FUNC_TARE);
  assign restart = (bcnt_r != '0) && (batch_tare_r != is_tare);
  assign acc_sum = (restart ? '0 : acc_r) + AccW'(samp);
  assign cnt_inc = (restart ? '0 : bcnt_r) + CntW'(1);
  assign batch_n = (sample_count_r == '0) ? CntW'(1) : sample_count_r;

  // Calibrate difference, signed, one bit wider than a sample.
  logic signed [RawW:0] cal_diff;
  logic [RawW-1:0]      cal_mag;
  assign cal_diff = $signed({1'b0, samp}) - $signed({1'b0, offset_r});
  assign cal_mag  = cal_diff[RawW] ? RawW'(-cal_diff) : cal_diff[RawW-1:0];

  // One restoring division step.
  logic [DivRW-1:0] rem_sh;
  logic             div_ge;
  logic [DivRW-1:0] rem_nxt;
  logic [DivNW-1:0] q_nxt;
  assign rem_sh  = {div_rem_r[DivRW-2:0], div_num_r[DivNW-1]};
  assign div_ge  = rem_sh >= {1'b0, div_den_r};
  assign rem_nxt = div_ge ? rem_sh - {1'b0, div_den_r} : rem_sh;
  assign q_nxt   = {div_q_r[DivNW-2:0], div_ge};

  // Average finished: net magnitude against the offset.
  logic [RawW-1:0]   avg_new;
  logic [RawW-1:0]   net;
  logic [DivDW-1:0]  scale_mag;
  assign avg_new   = q_nxt[RawW-1:0];
  assign net       = (avg_new > offset_r) ? avg_new - offset_r : offset_r - avg_new;
  assign scale_mag = scale_r[ScaleW-1] ? DivDW'(-scale_r) : DivDW'(scale_r);

  // Weight quotient finished: sign and saturation.
  logic signed [WgtW-1:0] wgt;
  logic                   wgt_sat;
  always_comb begin
    wgt     = '0;
    wgt_sat = 1'b0;
    if (net_zero_r) begin
      wgt = '0;
    end else if (neg_r) begin
      if (q_nxt > DivNW'(33'h080000000)) begin
        wgt     = {1'b1, {(WgtW-1){1'b0}}};
        wgt_sat = 1'b1;
      end else begin
        wgt = -$signed(q_nxt[WgtW-1:0]);
      end
    end else if (q_nxt > DivNW'(32'h7FFFFFFF)) begin
      wgt     = {1'b0, {(WgtW-1){1'b1}}};
      wgt_sat = 1'b1;
    end else begin
      wgt = $signed(q_nxt[WgtW-1:0]);
    end
  end

  // Effective filter weight: values above one are taken as one.
  logic [AlphaW-1:0] alpha_eff;
  assign alpha_eff = (alpha_now_r > AlphaW'(256)) ? AlphaW'(256) : alpha_now_r;

  // Shift-and-add step and the floor-divided filter update.
  logic signed [ProdW-1:0] mul_add;
  logic signed [WgtW-1:0]  filt_upd;
  assign mul_add  = mul_a_r[mul_cnt_r] ?
                    mul_p_r + (ProdW'(mul_d_r) <<< mul_cnt_r) : mul_p_r;
  assign filt_upd = filt_r + WgtW'(mul_add >>> 8);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= SAMPLE_COUNT_RST;
      alpha_start_r  <= ALPHA_START_RST;
      alpha_tare_r   <= ALPHA_TARE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SAMPLE_COUNT: sample_count_r <= cfg_wdata[CntW-1:0];
        CFG_ALPHA_START:  alpha_start_r  <= cfg_wdata;
        CFG_ALPHA_TARE:   alpha_tare_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r              <= ST_IDLE;
      offset_r             <= '0;
      scale_r              <= SCALE_RST;
      acc_r                <= '0;
      bcnt_r               <= '0;
      batch_tare_r         <= 1'b0;
      filt_r               <= '0;
      primed_r             <= 1'b0;
      alpha_now_r          <= ALPHA_START_RST;
      alpha_follows_tare_r <= 1'b0;
      out_valid_r          <= 1'b0;
      div_cnt_r            <= '0;
      mul_cnt_r            <= '0;
    end else begin
      // A finished item loads the output register; otherwise a taken result
      // empties it.
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      // A write to the register that the filter weight follows reloads it.
      if (cfg_we && cfg_addr == CFG_ALPHA_START && !alpha_follows_tare_r) begin
        alpha_now_r <= cfg_wdata;
      end
      if (cfg_we && cfg_addr == CFG_ALPHA_TARE && alpha_follows_tare_r) begin
        alpha_now_r <= cfg_wdata;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            sat_r <= 1'b0;
            case (in_func)
              FUNC_WEIGH, FUNC_TARE: begin
                batch_tare_r <= is_tare;
                if (cnt_inc < batch_n) begin
                  acc_r  <= acc_sum;
                  bcnt_r <= cnt_inc;
                end else begin
                  acc_r     <= '0;
                  bcnt_r    <= '0;
                  div_op_r  <= DOP_AVG;
                  div_num_r <= DivNW'(acc_sum);
                  div_den_r <= DivDW'(cnt_inc);
                  div_rem_r <= '0;
                  div_cnt_r <= DivCW'(DivNW);
                  state_r   <= ST_DIV;
                end
              end
              FUNC_CAL: begin
                avg_r <= samp;
                if (in_known_weight == '0 || cal_diff == '0) begin
                  kind_r  <= KIND_CAL_REJ;
                  state_r <= ST_OUT;
                end else begin
                  neg_r     <= cal_diff[RawW];
                  div_op_r  <= DOP_CAL;
                  div_num_r <= DivNW'({cal_mag, 8'b0});
                  div_den_r <= DivDW'(in_known_weight);
                  div_rem_r <= '0;
                  div_cnt_r <= DivCW'(DivNW);
                  state_r   <= ST_DIV;
                end
              end
              default: begin
                avg_r   <= '0;
                scale_r <= in_scale_value;
                kind_r  <= KIND_LOADED;
                state_r <= ST_OUT;
              end
            endcase
          end
        end

        ST_DIV: begin
          if (div_cnt_r != DivCW'(1)) begin
            div_rem_r <= rem_nxt;
            div_q_r   <= q_nxt;
            div_num_r <= {div_num_r[DivNW-2:0], 1'b0};
            div_cnt_r <= div_cnt_r - DivCW'(1);
          end else begin
            // Last step: the quotient is taken straight from the step logic.
            case (div_op_r)
              DOP_AVG: begin
                avg_r <= avg_new;
                if (batch_tare_r) begin
                  offset_r             <= avg_new;
                  alpha_follows_tare_r <= 1'b1;
                  alpha_now_r          <= alpha_tare_r;
                  primed_r             <= 1'b0;
                  filt_r               <= '0;
                  kind_r               <= KIND_TARE;
                  state_r              <= ST_OUT;
                end else begin
                  net_zero_r <= (net == '0);
                  neg_r      <= scale_r[ScaleW-1];
                  div_op_r   <= DOP_WGT;
                  div_num_r  <= {net, 16'b0};
                  div_den_r  <= scale_mag;
                  div_rem_r  <= '0;
                  div_cnt_r  <= DivCW'(DivNW);
                end
              end
              DOP_WGT: begin
                sat_r  <= wgt_sat;
                kind_r <= KIND_WEIGHT;
                if (!primed_r) begin
                  filt_r   <= wgt;
                  primed_r <= 1'b1;
                  state_r  <= ST_OUT;
                end else begin
                  mul_d_r   <= ScaleW'(wgt) - ScaleW'(filt_r);
                  mul_p_r   <= '0;
                  mul_a_r   <= alpha_eff;
                  mul_cnt_r <= '0;
                  state_r   <= ST_MUL;
                end
              end
              default: begin
                scale_r <= neg_r ? -$signed(q_nxt[ScaleW-1:0]) : $signed(q_nxt[ScaleW-1:0]);
                kind_r  <= KIND_CAL;
                state_r <= ST_OUT;
              end
            endcase
          end
        end

        ST_MUL: begin
          mul_p_r   <= mul_add;
          mul_cnt_r <= mul_cnt_r + 4'd1;
          if (mul_cnt_r == 4'(AlphaW - 1)) begin
            filt_r  <= filt_upd;
            state_r <= ST_OUT;
          end
        end

        ST_OUT: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Result payload is captured with the valid flag.
  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_free) begin
      out_kind_r   <= kind_r;
      out_weight_r <= filt_r;
      out_avg_r    <= avg_r;
      out_offset_r <= offset_r;
      out_scale_r  <= scale_r;
      out_sat_r    <= sat_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_weight_q    = out_weight_r;
  assign out_average_raw = out_avg_r;
  assign out_offset_now  = out_offset_r;
  assign out_scale_now   = out_scale_r;
  assign out_saturated   = out_sat_r;

  // The divider always has steps left while it runs.
  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (div_cnt_r != '0))
    else $error("divider running with no steps left");

  // The filter multiply only runs on a primed filter.
  a_mul_primed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> primed_r)
    else $error("filter update on an unprimed filter");

  // Only weight results can report saturation.
  a_sat_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r != KIND_WEIGHT) |-> !out_sat_r)
    else $error("saturation flagged on a non-weight result");

  // A tare result always leaves a cleared, unprimed filter.
  a_tare_filter: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && kind_r == KIND_TARE) |-> (!primed_r && filt_r == '0))
    else $error("tare left the filter primed");

endmodule

// ----- verif/tb_load_cell_weigh_conditioner.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Weigh conditioner testbench
// Drives converter words, calibrate and scale-load items into the weigh
// conditioner and checks every result, field by field, against a predictor
// tracking offset, scale, batch sums and low-pass filter, or a typed result.
// ---------------------------------------------------------------------------
module tb_load_cell_weigh_conditioner;
  import lcwc_pkg::*;

  // One result of the block, as it appears on the output channel.
  typedef struct packed {
    logic [2:0]               kind;
    logic signed [WgtW-1:0]   weight;
    logic [RawW-1:0]          avg;
    logic [RawW-1:0]          offset;
    logic signed [ScaleW-1:0] scale;
    logic                     sat;
  } weigh_res_t;

  // One row of the directed table. Rows with has_typed carry a result that
  // is known by inspection; the others are predicted.
  typedef struct {
    logic [1:0]               func;
    logic [RawW-1:0]          raw;
    logic [KwW-1:0]           kw;
    logic signed [ScaleW-1:0] sv;
    bit                       has_typed;
    weigh_res_t               typed;
  } stim_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CfgAW-1:0]         cfg_addr;
  logic [CfgDW-1:0]         cfg_wdata;
  logic                     in_valid;
  logic                     in_ready;
  logic [1:0]               in_func;
  logic [RawW-1:0]          in_raw_bits;
  logic [KwW-1:0]           in_known_weight;
  logic signed [ScaleW-1:0] in_scale_value;
  logic                     out_valid;
  logic                     out_ready;
  logic [2:0]               out_kind;
  logic signed [WgtW-1:0]   out_weight_q;
  logic [RawW-1:0]          out_average_raw;
  logic [RawW-1:0]          out_offset_now;
  logic signed [ScaleW-1:0] out_scale_now;
  logic                     out_saturated;

  always #5 clk = ~clk;

  load_cell_weigh_conditioner u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func),
    .in_raw_bits(in_raw_bits), .in_known_weight(in_known_weight),
    .in_scale_value(in_scale_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_weight_q(out_weight_q), .out_average_raw(out_average_raw),
    .out_offset_now(out_offset_now), .out_scale_now(out_scale_now),
    .out_saturated(out_saturated)
  );

  // -------------------------------------------------------------------------
  // Predictor state: a private copy of the registers and of the block state.
  // -------------------------------------------------------------------------
  logic [CntW-1:0]          reg_count;
  logic [AlphaW-1:0]        reg_alpha_start;
  logic [AlphaW-1:0]        reg_alpha_tare;
  logic [RawW-1:0]          zero_off;
  logic signed [ScaleW-1:0] scale_st;
  logic [AccW-1:0]          acc_sum;
  logic [CntW-1:0]          batch_n;
  bit                       batch_tare;
  logic signed [WgtW-1:0]   filt_w;
  bit                       filt_primed;
  logic [AlphaW-1:0]        alpha_cur;
  bit                       alpha_on_tare;

  weigh_res_t pending_q[$];
  int errors     = 0;
  int n_in       = 0;
  int n_out      = 0;
  int n_phases   = 0;
  bit calm       = 1'b0;
  int idle_count = 0;
  int stall_left = 0;

  // Scaled weight: |net| * 2^16 / scale, truncated toward zero and clipped
  // to the signed 32-bit range. A zero scale gives full scale unless the
  // net reading is zero as well.
  function automatic logic signed [WgtW-1:0] scaled_weight(logic [RawW-1:0] net,
                                                           output bit sat);
    longint s;
    longint unsigned num, den, mag;
    s   = scale_st;
    num = longint'(net) << 16;
    sat = 1'b0;
    if (s == 0) begin
      if (net == 0) return '0;
      sat = 1'b1;
      return 32'sh7FFFFFFF;
    end
    den = (s < 0) ? -s : s;
    mag = num / den;
    if (s < 0) begin
      if (mag > 64'h80000000) begin
        sat = 1'b1;
        return 32'sh80000000;
      end
      return WgtW'(-longint'(mag));
    end
    if (mag > 64'h7FFFFFFF) begin
      sat = 1'b1;
      return 32'sh7FFFFFFF;
    end
    return WgtW'(mag);
  endfunction

  // First-order low-pass. The first value after reset or a tare passes
  // straight through; after that y moves by floor(alpha * (x - y) / 256).
  function automatic void filter_step(logic signed [WgtW-1:0] x);
    longint a, d;
    a = (alpha_cur > 256) ? 256 : alpha_cur;
    if (!filt_primed) begin
      filt_w      = x;
      filt_primed = 1'b1;
      return;
    end
    d      = longint'(x) - longint'(filt_w);
    filt_w = WgtW'(longint'(filt_w) + ((a * d) >>> 8));
  endfunction

  function automatic void predict_cfg(logic [CfgAW-1:0] addr, logic [CfgDW-1:0] d);
    case (addr)
      CFG_SAMPLE_COUNT: reg_count = d[CntW-1:0];
      CFG_ALPHA_START: begin
        reg_alpha_start = d;
        if (!alpha_on_tare) alpha_cur = d;
      end
      CFG_ALPHA_TARE: begin
        reg_alpha_tare = d;
        if (alpha_on_tare) alpha_cur = d;
      end
      default: ;
    endcase
  endfunction

  // Works out what one accepted item does; returns 1 when it gives a result.
  function automatic bit predict_item(logic [1:0] func, logic [RawW-1:0] raw,
                                      logic [KwW-1:0] kw, logic signed [ScaleW-1:0] sv,
                                      output weigh_res_t r);
    logic [RawW-1:0] sample, net;
    logic [AccW-1:0] avg32;
    longint diff;
    longint unsigned mag;
    bit tare, sat;
    int n;
    sample = raw ^ 24'h800000;
    r      = '0;
    sat    = 1'b0;
    if (func == FUNC_WEIGH || func == FUNC_TARE) begin
      tare = (func == FUNC_TARE);
      n    = (reg_count == 0) ? 1 : reg_count;
      // A sample of the other kind throws away the open batch.
      if (batch_n != 0 && batch_tare != tare) begin
        batch_n = '0;
        acc_sum = '0;
      end
      batch_tare = tare;
      acc_sum    = acc_sum + AccW'(sample);
      batch_n    = batch_n + CntW'(1);
      if (batch_n < n) return 1'b0;
      avg32   = acc_sum / batch_n;
      r.avg   = avg32[RawW-1:0];
      acc_sum = '0;
      batch_n = '0;
      if (tare) begin
        zero_off      = r.avg;
        alpha_on_tare = 1'b1;
        alpha_cur     = reg_alpha_tare;
        filt_primed   = 1'b0;
        filt_w        = '0;
        r.kind        = KIND_TARE;
      end else begin
        net = (r.avg > zero_off) ? r.avg - zero_off : zero_off - r.avg;
        filter_step(scaled_weight(net, sat));
        r.kind = KIND_WEIGHT;
      end
    end else if (func == FUNC_CAL) begin
      diff  = longint'(sample) - longint'(zero_off);
      r.avg = sample;
      if (kw == 0 || diff == 0) begin
        r.kind = KIND_CAL_REJ;
      end else begin
        mag      = ((diff < 0) ? -diff : diff) << 8;
        mag      = mag / kw;
        scale_st = ScaleW'((diff < 0) ? -longint'(mag) : longint'(mag));
        r.kind   = KIND_CAL;
      end
    end else begin
      scale_st = sv;
      r.kind   = KIND_LOADED;
    end
    r.weight = filt_w;
    r.offset = zero_off;
    r.scale  = scale_st;
    r.sat    = sat;
    return 1'b1;
  endfunction

  // -------------------------------------------------------------------------
  // Sender side. Fields change only at the edge that completes a transfer,
  // so valid and payload stay steady while the block holds ready low.
  // -------------------------------------------------------------------------
  task automatic send_item(logic [1:0] func, logic [RawW-1:0] raw, logic [KwW-1:0] kw,
                           logic signed [ScaleW-1:0] sv, bit has_typed,
                           weigh_res_t typed);
    weigh_res_t r;
    in_valid        <= 1'b1;
    in_func         <= func;
    in_raw_bits     <= raw;
    in_known_weight <= kw;
    in_scale_value  <= sv;
    do @(posedge clk); while (!in_ready);
    n_in++;
    if (predict_item(func, raw, kw, sv, r)) pending_q.push_back(has_typed ? typed : r);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // Drain: let every expected result come out, then give the block time to
  // finish any batch step that produces nothing before touching registers.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (110) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CfgAW-1:0] addr, logic [CfgDW-1:0] d);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= d;
    @(posedge clk);
    predict_cfg(addr, d);
  endtask

  function automatic logic [AlphaW-1:0] pick_alpha();
    case ($urandom_range(0, 5))
      0: return 9'd0;
      1: return 9'd1;
      2: return 9'd256;
      3: return 9'd511;
      default: return AlphaW'($urandom_range(1, 256));
    endcase
  endfunction

  function automatic logic signed [ScaleW-1:0] pick_scale();
    logic signed [ScaleW-1:0] s;
    case ($urandom_range(0, 9))
      0: s = '0;
      1: s = {$urandom(), 1'b0} | ScaleW'($urandom_range(0, 1));
      2: s = -$signed({1'b0, 32'($urandom_range(1, 4000))});
      3: s = ScaleW'($urandom_range(1, 300));
      default: s = ScaleW'($urandom_range(2000, 200000));
    endcase
    return s;
  endfunction

  // One phase of random traffic. Weigh and tare samples mostly come as whole
  // batches around one level, so batches close and the filter gets exercised;
  // some runs are cut short to leave partial batches open.
  task automatic random_phase(int items);
    int start, len, pick;
    logic [RawW-1:0] level, raw;
    logic [KwW-1:0] kw;
    weigh_res_t none;
    none  = '0;
    start = n_in;
    while (n_in - start < items) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        len = (reg_count == 0) ? 1 : reg_count;
        if ($urandom_range(0, 7) == 0) len = $urandom_range(1, len);
        level = RawW'($urandom());
        for (int i = 0; i < len; i++) begin
          raw = ($urandom_range(0, 9) == 0) ? RawW'($urandom())
                                            : RawW'(level + $urandom_range(0, 255));
          send_item((pick < 60) ? FUNC_WEIGH : FUNC_TARE, raw, KwW'($urandom()),
                    ScaleW'($urandom()), 1'b0, none);
        end
      end else if (pick < 88) begin
        raw = RawW'($urandom());
        // Now and then aim the sample exactly at the offset.
        if ($urandom_range(0, 9) == 0) raw = zero_off ^ 24'h800000;
        kw  = ($urandom_range(0, 9) == 0) ? '0 : KwW'($urandom());
        if ($urandom_range(0, 3) == 0) kw = KwW'($urandom_range(1, 300));
        send_item(FUNC_CAL, raw, kw, ScaleW'($urandom()), 1'b0, none);
      end else begin
        send_item(FUNC_LOAD, RawW'($urandom()), KwW'($urandom()), pick_scale(), 1'b0,
                  none);
      end
    end
  endtask

  function automatic stim_row_t row(logic [1:0] func, logic [RawW-1:0] raw,
                                    logic [KwW-1:0] kw, logic signed [ScaleW-1:0] sv);
    stim_row_t t;
    t.func      = func;
    t.raw       = raw;
    t.kw        = kw;
    t.sv        = sv;
    t.has_typed = 1'b0;
    t.typed     = '0;
    return t;
  endfunction

  function automatic stim_row_t row_typed(logic [1:0] func, logic [RawW-1:0] raw,
                                          logic [KwW-1:0] kw,
                                          logic signed [ScaleW-1:0] sv,
                                          logic [2:0] kind, logic [RawW-1:0] avg,
                                          logic signed [ScaleW-1:0] scale);
    stim_row_t t;
    t           = row(func, raw, kw, sv);
    t.has_typed = 1'b1;
    t.typed     = '{kind: kind, weight: '0, avg: avg, offset: '0, scale: scale,
                    sat: 1'b0};
    return t;
  endfunction

  // -------------------------------------------------------------------------
  // Main sequence.
  // -------------------------------------------------------------------------
  initial begin
    stim_row_t table_rows[$];
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_addr        <= CFG_SAMPLE_COUNT;
    cfg_wdata       <= '0;
    in_valid        <= 1'b0;
    in_func         <= FUNC_WEIGH;
    in_raw_bits     <= '0;
    in_known_weight <= '0;
    in_scale_value  <= '0;

    reg_count       = SAMPLE_COUNT_RST;
    reg_alpha_start = ALPHA_START_RST;
    reg_alpha_tare  = ALPHA_TARE_RST;
    zero_off        = '0;
    scale_st        = SCALE_RST;
    acc_sum         = '0;
    batch_n         = '0;
    batch_tare      = 1'b0;
    filt_w          = '0;
    filt_primed     = 1'b0;
    alpha_cur       = ALPHA_START_RST;
    alpha_on_tare   = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Batches of two keep the directed part short.
    cfg_write(CFG_SAMPLE_COUNT, 9'd2);
    cfg_we <= 1'b0;
    @(posedge clk);

    // Rejected calibrations (zero weight, then a sample equal to the offset),
    // scale loads at both ends of the range, then batches, kind changes in
    // an open batch, a zero calibrate quotient, a zero and a negative scale.
    table_rows.push_back(row_typed(FUNC_CAL, 24'h000000, 20'h0, '0, KIND_CAL_REJ,
                                   24'h800000, SCALE_RST));
    table_rows.push_back(row_typed(FUNC_CAL, 24'h800000, 20'h1, '0, KIND_CAL_REJ,
                                   24'h000000, SCALE_RST));
    table_rows.push_back(row_typed(FUNC_LOAD, 24'hFFFFFF, 20'hFFFFF, 33'h0FFFFFFFF,
                                   KIND_LOADED, '0, 33'h0FFFFFFFF));
    table_rows.push_back(row_typed(FUNC_LOAD, 24'h0, 20'h0, 33'h100000000,
                                   KIND_LOADED, '0, 33'h100000000));
    table_rows.push_back(row_typed(FUNC_LOAD, 24'h0, 20'h0, SCALE_RST,
                                   KIND_LOADED, '0, SCALE_RST));
    table_rows.push_back(row(FUNC_TARE, 24'h800000, 20'h0, '0));
    table_rows.push_back(row_typed(FUNC_TARE, 24'h800000, 20'h0, '0, KIND_TARE,
                                   24'h000000, SCALE_RST));
    table_rows.push_back(row(FUNC_WEIGH, 24'h7FFFFF, 20'h0, '0));
    table_rows.push_back(row(FUNC_TARE, 24'h000000, 20'h0, '0));
    table_rows.push_back(row(FUNC_WEIGH, 24'h000000, 20'h0, '0));
    table_rows.push_back(row(FUNC_WEIGH, 24'h7FFFFF, 20'h0, '0));
    table_rows.push_back(row(FUNC_CAL, 24'h7FFFFF, 20'hFFFFF, '0));
    table_rows.push_back(row(FUNC_CAL, 24'h800001, 20'hFFFFF, '0));
    table_rows.push_back(row(FUNC_WEIGH, 24'h800001, 20'h0, '0));
    table_rows.push_back(row(FUNC_WEIGH, 24'h800001, 20'h0, '0));
    table_rows.push_back(row(FUNC_WEIGH, 24'h800000, 20'h0, '0));
    table_rows.push_back(row(FUNC_WEIGH, 24'h800000, 20'h0, '0));
    table_rows.push_back(row(FUNC_LOAD, 24'h0, 20'h0, 33'h1FFFFFFFF));
    table_rows.push_back(row(FUNC_WEIGH, 24'h7FFFFF, 20'h0, '0));
    table_rows.push_back(row(FUNC_WEIGH, 24'h7FFFFF, 20'h0, '0));
    table_rows.push_back(row(FUNC_LOAD, 24'h0, 20'h0, 33'd256));
    table_rows.push_back(row(FUNC_TARE, 24'h7FFFFF, 20'h0, '0));
    table_rows.push_back(row(FUNC_TARE, 24'h7FFFFF, 20'h0, '0));
    table_rows.push_back(row(FUNC_WEIGH, 24'h800000, 20'h0, '0));
    table_rows.push_back(row(FUNC_WEIGH, 24'h800000, 20'h0, '0));
    foreach (table_rows[i])
      send_item(table_rows[i].func, table_rows[i].raw, table_rows[i].kw,
                table_rows[i].sv, table_rows[i].has_typed, table_rows[i].typed);

    // Random phases, each under a new register setting. Phase 1 uses a zero
    // count and phase 3 the longest batches; open batches left by a phase
    // see the new count, which covers a count lowered mid-batch.
    for (int ph = 0; ph < 12; ph++) begin
      drain_block();
      n_phases++;
      case (ph)
        1:       cfg_write(CFG_SAMPLE_COUNT, 9'd0);
        3:       cfg_write(CFG_SAMPLE_COUNT, 9'd255);
        0, 6:    cfg_write(CFG_SAMPLE_COUNT, 9'd1);
        default: cfg_write(CFG_SAMPLE_COUNT, CfgDW'($urandom_range(1, 8)));
      endcase
      cfg_write(CFG_ALPHA_START, pick_alpha());
      cfg_write(CFG_ALPHA_TARE, pick_alpha());
      cfg_we <= 1'b0;
      if (ph == 11) calm = 1'b1;
      random_phase(125);
    end

    drain_block();
    $display("Sent %0d items in %0d register settings; %0d results checked.",
             n_in, n_phases + 1, n_out);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // -------------------------------------------------------------------------
  // Receiver side: random stall bursts, and each result transfer compared
  // with the oldest expectation.
  // -------------------------------------------------------------------------
  initial out_ready <= 1'b0;

  always @(posedge clk) begin
    weigh_res_t e;
    if (rst_n && out_valid && out_ready) begin
      n_out++;
      if (pending_q.size() == 0) begin
        $error("result transfer with nothing expected (kind %0d)", out_kind);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (out_kind !== e.kind) begin
          $error("kind expected %0d got %0d", e.kind, out_kind);
          errors++;
        end
        if (out_weight_q !== e.weight) begin
          $error("weight_q expected %0d got %0d", e.weight, out_weight_q);
          errors++;
        end
        if (out_average_raw !== e.avg) begin
          $error("average_raw expected %h got %h", e.avg, out_average_raw);
          errors++;
        end
        if (out_offset_now !== e.offset) begin
          $error("offset_now expected %h got %h", e.offset, out_offset_now);
          errors++;
        end
        if (out_scale_now !== e.scale) begin
          $error("scale_now expected %0d got %0d", e.scale, out_scale_now);
          errors++;
        end
        if (out_saturated !== e.sat) begin
          $error("saturated expected %0d got %0d", e.sat, out_saturated);
          errors++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 8);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: a long stretch without any transfer means the block hung.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_count <= 0;
    end else if (idle_count >= 3000) begin
      $display("Timeout: no transfer for %0d cycles.", idle_count);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

endmodule

// ----- files.f -----
hw/rtl/lcwc_pkg.sv
hw/rtl/load_cell_weigh_conditioner.sv
verif/tb_load_cell_weigh_conditioner.sv
